### rtl/qvic_pkg.sv
// ----------------------------------------------------------------------------
// qvic_pkg
// Types, codes and helpers shared by the quad vectored interrupt controller.
// ----------------------------------------------------------------------------
package qvic_pkg;

	localparam int NUM_CTRL       = 4;
	localparam int LINES_PER_CTRL = 8;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_ACK   = 2'd2;
	localparam logic [1:0] REQ_SET   = 2'd3;

	localparam int MODE_IM = 0;
	localparam int MODE_VS = 2;
	localparam int MODE_MM = 7;

	// Command codes, bits 7..3 of a command byte
	localparam logic [4:0] CMD_CLR_IRR_MASK  = 5'h02;
	localparam logic [4:0] CMD_CLR_IRR_MBIT  = 5'h03;
	localparam logic [4:0] CMD_CLR_MASK      = 5'h04;
	localparam logic [4:0] CMD_CLR_MBIT      = 5'h05;
	localparam logic [4:0] CMD_SET_MASK      = 5'h06;
	localparam logic [4:0] CMD_SET_MBIT      = 5'h07;
	localparam logic [4:0] CMD_CLR_IRR       = 5'h08;
	localparam logic [4:0] CMD_CLR_IRR_BIT   = 5'h09;
	localparam logic [4:0] CMD_SET_IRR       = 5'h0A;
	localparam logic [4:0] CMD_SET_IRR_BIT   = 5'h0B;
	localparam logic [4:0] CMD_CLR_ISR       = 5'h0E;
	localparam logic [4:0] CMD_CLR_ISR_BIT   = 5'h0F;
	localparam logic [4:0] CMD_MODE_LO_A     = 5'h10;
	localparam logic [4:0] CMD_MODE_LO_B     = 5'h11;
	localparam logic [4:0] CMD_MODE_LO_C     = 5'h12;
	localparam logic [4:0] CMD_MODE_LO_D     = 5'h13;
	localparam logic [4:0] CMD_MODE_HI_A     = 5'h14;
	localparam logic [4:0] CMD_MODE_HI_B     = 5'h15;
	localparam logic [4:0] CMD_PSEL_MASK_A   = 5'h16;
	localparam logic [4:0] CMD_PSEL_MASK_B   = 5'h17;
	localparam logic [4:0] CMD_PSEL_ACR_A    = 5'h18;
	localparam logic [4:0] CMD_PSEL_ACR_B    = 5'h19;
	localparam logic [4:0] CMD_PSEL_RESP     = 5'h1C;

	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_MASK = 2'd1,
		SEL_ACR  = 2'd2,
		SEL_RESP = 2'd3
	} sel_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] ctrl_index;
		logic       port_select;
		logic [7:0] write_data;
		logic [7:0] request_bits;
	} qvic_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] vector_out;
		logic       ack_found;
		logic       int_line;
	} qvic_rsp_t;

	// Lowest set bit; bit 3 set when none
	function automatic logic [3:0] lowest_line(input logic [7:0] live);
		logic [3:0] n;
		n = 4'd8;
		for (int i = LINES_PER_CTRL - 1; i >= 0; i--) begin
			if (live[i]) n = 4'(i);
		end
		return n;
	endfunction

endpackage

### rtl/quad_vectored_interrupt_controller.sv
// ----------------------------------------------------------------------------
// quad_vectored_interrupt_controller
// Four eight-line vectored interrupt controllers behind one request channel.
// ----------------------------------------------------------------------------
// Request path: an accepted request is held in the input register, worked in one
// pass of logic, and its response is registered in the response register.
// Throughput: one request per cycle; the input stalls only while the input
// register is full and the response register holds a stalled response.
// Reset: asynchronous, clears all controller registers, masks to all ones,
// response vectors to zero; no clearing pass is needed.
module quad_vectored_interrupt_controller import qvic_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  qvic_req_t req,
	input  logic      req_valid,
	output logic      req_stall,
	output qvic_rsp_t rsp,
	output logic      rsp_valid,
	input  logic      rsp_stall
);

	logic       v_s1;
	qvic_req_t  req_s1;
	logic       rsp_valid_q;
	qvic_rsp_t  rsp_q;

	logic [7:0] request_q  [NUM_CTRL];
	logic [7:0] service_q  [NUM_CTRL];
	logic [7:0] mask_q     [NUM_CTRL];
	logic [7:0] autoclr_q  [NUM_CTRL];
	logic [7:0] mode_q     [NUM_CTRL];
	sel_t       psel_q     [NUM_CTRL];
	logic [2:0] pvec_q     [NUM_CTRL];
	logic [7:0] vectors_q  [NUM_CTRL][LINES_PER_CTRL];

	logic [7:0] request_n  [NUM_CTRL];
	logic [7:0] service_n  [NUM_CTRL];
	logic [7:0] mask_n     [NUM_CTRL];
	logic [7:0] autoclr_n  [NUM_CTRL];
	logic [7:0] mode_n     [NUM_CTRL];
	sel_t       psel_n     [NUM_CTRL];
	logic [2:0] pvec_n     [NUM_CTRL];
	logic [7:0] vectors_n  [NUM_CTRL][LINES_PER_CTRL];

	logic [3:0] pend       [NUM_CTRL];
	logic       asserts    [NUM_CTRL];
	logic       ack_hit;
	logic [1:0] ack_ctl;
	logic [2:0] ack_line;
	logic [7:0] wbit;
	logic [7:0] wd;
	qvic_rsp_t  res;

	logic advance;
	logic fire;

	assign advance   = !(rsp_valid_q && rsp_stall);
	assign fire      = v_s1 && advance;
	assign req_stall = v_s1 && !advance;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		request_n = request_q;
		service_n = service_q;
		mask_n    = mask_q;
		autoclr_n = autoclr_q;
		mode_n    = mode_q;
		psel_n    = psel_q;
		pvec_n    = pvec_q;
		vectors_n = vectors_q;
		res       = '0;
		ack_hit   = 1'b0;
		ack_ctl   = '0;
		ack_line  = '0;
		wd        = req_s1.write_data;
		wbit      = 8'd1 << wd[2:0];

		for (int k = 0; k < NUM_CTRL; k++) begin
			pend[k]    = lowest_line(request_q[k] & ~mask_q[k]);
			asserts[k] = !pend[k][3] && mode_q[k][MODE_MM] && !mode_q[k][MODE_IM];
		end
		for (int k = NUM_CTRL - 1; k >= 0; k--) begin
			if (asserts[k]) begin
				ack_hit  = 1'b1;
				ack_ctl  = 2'(k);
				ack_line = pend[k][2:0];
			end
		end

		for (int k = 0; k < NUM_CTRL; k++) begin
			if (req_s1.ctrl_index == 2'(k)) begin
				case (req_s1.req_type)
					REQ_READ: begin
						if (req_s1.port_select) begin
							res.read_data = {pend[k][3], 1'b0, mode_q[k][MODE_IM],
								mode_q[k][MODE_VS], mode_q[k][MODE_MM],
								pend[k][3] ? 3'd0 : pend[k][2:0]};
						end else begin
							case (mode_q[k][6:5])
								2'd0:    res.read_data = service_q[k];
								2'd1:    res.read_data = mask_q[k];
								2'd2:    res.read_data = request_q[k];
								default: res.read_data = autoclr_q[k];
							endcase
						end
					end
					REQ_WRITE: begin
						if (!req_s1.port_select) begin
							case (psel_q[k])
								SEL_MASK: mask_n[k]    = wd;
								SEL_ACR:  autoclr_n[k] = wd;
								SEL_RESP: vectors_n[k][pvec_q[k]] = wd;
								default: ;
							endcase
						end else if (wd == 8'd0) begin
							psel_n[k]    = SEL_NONE;
							request_n[k] = '0;
							service_n[k] = '0;
							mask_n[k]    = '1;
							autoclr_n[k] = '0;
							mode_n[k]    = '0;
						end else begin
							case (wd[7:3]) inside
								CMD_CLR_IRR_MASK: begin
									request_n[k] = '0;
									mask_n[k]    = '0;
								end
								CMD_CLR_IRR_MBIT: begin
									request_n[k] = request_q[k] & ~wbit;
									mask_n[k]    = mask_q[k] & ~wbit;
								end
								CMD_CLR_MASK:    mask_n[k]    = '0;
								CMD_CLR_MBIT:    mask_n[k]    = mask_q[k] & ~wbit;
								CMD_SET_MASK:    mask_n[k]    = '1;
								CMD_SET_MBIT:    mask_n[k]    = mask_q[k] | wbit;
								CMD_CLR_IRR:     request_n[k] = '0;
								CMD_CLR_IRR_BIT: request_n[k] = request_q[k] & ~wbit;
								CMD_SET_IRR:     request_n[k] = '1;
								CMD_SET_IRR_BIT: request_n[k] = request_q[k] | wbit;
								CMD_CLR_ISR:     service_n[k] = '0;
								CMD_CLR_ISR_BIT: service_n[k] = service_q[k] & ~wbit;
								CMD_MODE_LO_A, CMD_MODE_LO_B, CMD_MODE_LO_C, CMD_MODE_LO_D:
									mode_n[k] = {mode_q[k][7:5], wd[4:0]};
								CMD_MODE_HI_A, CMD_MODE_HI_B: begin
									mode_n[k][6:5] = wd[3:2];
									if (wd[1:0] == 2'd1)
										mode_n[k][MODE_MM] = 1'b1;
									else if (wd[1:0] == 2'd2)
										mode_n[k][MODE_MM] = 1'b0;
								end
								CMD_PSEL_MASK_A, CMD_PSEL_MASK_B: psel_n[k] = SEL_MASK;
								CMD_PSEL_ACR_A, CMD_PSEL_ACR_B:   psel_n[k] = SEL_ACR;
								CMD_PSEL_RESP: begin
									psel_n[k] = SEL_RESP;
									pvec_n[k] = wd[2:0];
								end
								default: ;
							endcase
						end
					end
					REQ_SET: request_n[k] = request_q[k] | req_s1.request_bits;
					default: ;
				endcase
			end
		end

		if (req_s1.req_type == REQ_ACK && ack_hit) begin
			res.ack_found = 1'b1;
			for (int k = 0; k < NUM_CTRL; k++) begin
				if (ack_ctl == 2'(k)) begin
					res.vector_out = mode_q[k][MODE_VS] ? vectors_q[k][0]
						: vectors_q[k][ack_line];
					request_n[k][ack_line] = 1'b0;
					if (!autoclr_q[k][ack_line])
						service_n[k][ack_line] = 1'b1;
				end
			end
		end

		for (int k = 0; k < NUM_CTRL; k++) begin
			if (|(request_n[k] & ~mask_n[k]) && mode_n[k][MODE_MM] && !mode_n[k][MODE_IM])
				res.int_line = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!req_stall) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CTRL; k++) begin
				request_q[k] <= '0;
				service_q[k] <= '0;
				mask_q[k]    <= '1;
				autoclr_q[k] <= '0;
				mode_q[k]    <= '0;
				psel_q[k]    <= SEL_NONE;
				pvec_q[k]    <= '0;
				for (int i = 0; i < LINES_PER_CTRL; i++) begin
					vectors_q[k][i] <= '0;
				end
			end
		end else if (fire) begin
			request_q <= request_n;
			service_q <= service_n;
			mask_q    <= mask_n;
			autoclr_q <= autoclr_n;
			mode_q    <= mode_n;
			psel_q    <= psel_n;
			pvec_q    <= pvec_n;
			vectors_q <= vectors_n;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v_s1 && rsp_valid_q && rsp_stall))
		else $error("request stalled without a blocked response");

	a_fire_resp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("processed request left no response");

	a_no_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.ack_found) |-> (rsp_q.vector_out == 8'd0))
		else $error("vector given without an acknowledge hit");

	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req_s1.req_type == REQ_ACK && ack_hit)
		|=> !request_q[$past(ack_ctl)][$past(ack_line)])
		else $error("acknowledged request bit not cleared");

endmodule
